// File: sv/lsae_pkg.sv
`default_nettype none
// Shared types, register indexes, frame kinds and lookup tables for the
// LED strip animation engine. No dependencies.

package lsae_pkg;

    // Strip size and derived widths.
    localparam int MAX_LEDS    = 64;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 6;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_ANIM_ID   = 3'd1;
    localparam logic [2:0] REG_COLOR_ID  = 3'd2;
    localparam logic [2:0] REG_LED_COUNT = 3'd3;
    localparam logic [2:0] REG_BRIGHT    = 3'd4;
    localparam logic [2:0] REG_INTERVAL  = 3'd5;
    localparam logic [2:0] REG_COUNT     = 3'd6;

    // Mode codes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_MULTI  = 2'd2;

    // Frame kinds decided by the front end.
    localparam logic [2:0] KIND_BREATH  = 3'd0;
    localparam logic [2:0] KIND_CHASE   = 3'd1;
    localparam logic [2:0] KIND_FILL    = 3'd2;
    localparam logic [2:0] KIND_WHEEL   = 3'd3;
    localparam logic [2:0] KIND_THEATRE = 3'd4;
    localparam logic [2:0] KIND_SWAP    = 3'd5;

    // Divider and queue sizing.
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Fixed levels and colors.
    localparam logic [8:0] LEVEL_FULL = 9'd256;
    localparam logic [8:0] LEVEL_NEAR = 9'd102;
    localparam logic [8:0] LEVEL_DIM  = 9'd20;
    localparam logic [7:0] PRESET_ON  = 8'd125;
    localparam logic [7:0] PRESET_ORG = 8'd60;
    localparam logic [8:0] MAX_PCT    = 9'd200;

    // Registered configuration, already saturated where used.
    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       anim_id;
        logic [7:0]       color_id;
        logic [CNT_W-1:0] n;
        logic [7:0]       pct;
        logic [15:0]      interval;
    } cfg_t;

    // One frame as handed from front to back.
    typedef struct packed {
        logic [2:0]       kind;
        logic [CNT_W-1:0] n;
        logic [7:0]       base_r;
        logic [7:0]       base_g;
        logic [7:0]       base_b;
        logic [8:0]       level;
        logic [CNT_W-1:0] aux;
        logic [8:0]       qstep;
        logic [7:0]       wofs;
        logic             swap_a;
    } frame_t;

    // Breathing level for a phase modulo 24, Q8.
    function automatic logic [8:0] breath_level(input logic [4:0] k);
        logic [8:0] lv;
        begin
            unique case (k)
                5'd0:  lv = 9'd147;
                5'd1:  lv = 9'd175;
                5'd2:  lv = 9'd202;
                5'd3:  lv = 9'd224;
                5'd4:  lv = 9'd241;
                5'd5:  lv = 9'd252;
                5'd6:  lv = 9'd256;
                5'd7:  lv = 9'd252;
                5'd8:  lv = 9'd241;
                5'd9:  lv = 9'd224;
                5'd10: lv = 9'd202;
                5'd11: lv = 9'd175;
                5'd12: lv = 9'd147;
                5'd13: lv = 9'd119;
                5'd14: lv = 9'd93;
                5'd15: lv = 9'd70;
                5'd16: lv = 9'd53;
                5'd17: lv = 9'd42;
                5'd18: lv = 9'd38;
                5'd19: lv = 9'd42;
                5'd20: lv = 9'd53;
                5'd21: lv = 9'd70;
                5'd22: lv = 9'd93;
                5'd23: lv = 9'd119;
                default: lv = 9'd0;
            endcase
            return lv;
        end
    endfunction

    // Preset colors; id zero and ids of eight and above fall back to white.
    function automatic logic [23:0] preset_rgb(input logic [7:0] id);
        logic [23:0] c;
        begin
            unique case (id)
                8'd1:    c = {PRESET_ON, 8'd0, 8'd0};
                8'd2:    c = {8'd0, PRESET_ON, 8'd0};
                8'd3:    c = {8'd0, 8'd0, PRESET_ON};
                8'd4:    c = {PRESET_ON, PRESET_ON, 8'd0};
                8'd5:    c = {8'd0, PRESET_ON, PRESET_ON};
                8'd6:    c = {PRESET_ON, 8'd0, PRESET_ON};
                8'd7:    c = {PRESET_ON, PRESET_ORG, 8'd0};
                default: c = {PRESET_ON, PRESET_ON, PRESET_ON};
            endcase
            return c;
        end
    endfunction

    // Frame kind from mode and animation id.
    function automatic logic [2:0] frame_kind(input logic [1:0] mode, input logic [7:0] anim);
        logic [2:0] k;
        begin
            if (mode == MODE_SINGLE) begin
                k = (anim == 8'd0) ? KIND_BREATH : ((anim == 8'd1) ? KIND_CHASE : KIND_FILL);
            end
            else begin
                k = (anim == 8'd0) ? KIND_WHEEL : ((anim == 8'd1) ? KIND_THEATRE : KIND_SWAP);
            end
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/lsae_div.sv
`default_nettype none
// Iterative restoring divider, one quotient bit per cycle, 32-bit dividend
// by a 7-bit divisor. Depends on lsae_pkg.

module lsae_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [31:0]                  dividend,
    input  wire logic [lsae_pkg::CNT_W-1:0]   divisor,
    output logic                              done,
    output logic [31:0]                       quotient,
    output logic [lsae_pkg::CNT_W-1:0]        remainder
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [lsae_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [31:0]                        quo_reg;
    logic [lsae_pkg::CNT_W-1:0]         rem_reg;
    logic [lsae_pkg::CNT_W-1:0]         dvs_reg;
    logic [lsae_pkg::CNT_W:0]           trial;
    logic                               ge;
    logic [lsae_pkg::CNT_W:0]           diff;
    logic [lsae_pkg::CNT_W-1:0]         rem_next;
    logic [31:0]                        quo_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[31]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[lsae_pkg::CNT_W-1:0] : trial[lsae_pkg::CNT_W-1:0];
        quo_next = {quo_reg[30:0], ge};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == lsae_pkg::DIV_CNT_W'(lsae_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: sv/lsae_front.sv
`default_nettype none
// Front end: accepts time items, decides whether a frame is due, keeps the
// frame phase and builds one frame descriptor. Depends on lsae_pkg, lsae_div.

module lsae_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lsae_pkg::cfg_t     cfg,
    input  wire logic               cfg_clear,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        now_ms,
    output logic                    push,
    output lsae_pkg::frame_t        push_data,
    input  wire logic               queue_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [31:0]                    phase_reg;
    logic [31:0]                    last_reg;
    logic                           fv_reg;
    lsae_pkg::frame_t               frame_reg;
    logic                           accept;
    logic                           due;
    logic [31:0]                    elapsed;
    logic [31:0]                    phase_inc;
    logic [2:0]                     kind;
    logic [31:0]                    div_dividend;
    logic [lsae_pkg::CNT_W-1:0]     div_divisor;
    logic                           div_done;
    logic [31:0]                    div_quo;
    logic [lsae_pkg::CNT_W-1:0]     div_rem;
    logic                           start;
    logic [23:0]                    base;

    // Frame decision for the item on the input.
    always_comb
    begin
        accept    = in_valid && (state_reg == ST_IDLE);
        elapsed   = now_ms - last_reg;
        phase_inc = phase_reg + 32'd1;
        due       = ((cfg.mode == lsae_pkg::MODE_SINGLE) || (cfg.mode == lsae_pkg::MODE_MULTI))
                    && (cfg.n != '0)
                    && (!fv_reg || (elapsed >= {16'd0, cfg.interval}));
        start     = accept && due;
        kind      = lsae_pkg::frame_kind(cfg.mode, cfg.anim_id);
    end

    // Divider operands per frame kind: each kind needs only one division.
    always_comb
    begin
        div_dividend = phase_inc;
        unique case (kind)
            lsae_pkg::KIND_BREATH:  div_divisor = 7'd24;
            lsae_pkg::KIND_CHASE:   div_divisor = cfg.n;
            lsae_pkg::KIND_FILL:    div_divisor = cfg.n + 7'd1;
            lsae_pkg::KIND_WHEEL:
            begin
                div_dividend = 32'd256;
                div_divisor  = cfg.n;
            end
            lsae_pkg::KIND_THEATRE: div_divisor = 7'd3;
            default:                div_divisor = 7'd1;
        endcase
    end

    lsae_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_PUSH;
            ST_PUSH: if (!queue_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer and frame timing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            last_reg  <= '0;
            fv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_clear)
            begin
                phase_reg <= '0;
                last_reg  <= '0;
                fv_reg    <= 1'b0;
            end
            else if (start)
            begin
                phase_reg <= phase_inc;
                last_reg  <= now_ms;
                fv_reg    <= 1'b1;
            end
        end
    end

    assign base = lsae_pkg::preset_rgb(cfg.color_id);

    // Descriptor captured when the division finishes.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV) && div_done)
        begin
            frame_reg.kind   <= kind;
            frame_reg.n      <= cfg.n;
            frame_reg.base_r <= base[23:16];
            frame_reg.base_g <= base[15:8];
            frame_reg.base_b <= base[7:0];
            frame_reg.level  <= lsae_pkg::breath_level(div_rem[4:0]);
            frame_reg.aux    <= div_rem;
            frame_reg.qstep  <= div_quo[8:0];
            frame_reg.wofs   <= phase_reg[7:0] + {phase_reg[5:0], 2'b00};
            frame_reg.swap_a <= ~phase_reg[2];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign push      = (state_reg == ST_PUSH) && !queue_full;
    assign push_data = frame_reg;

endmodule

`default_nettype wire

// File: sv/lsae_queue.sv
`default_nettype none
// Short queue of frame descriptors between front and back end.
// Depends on lsae_pkg.

module lsae_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lsae_pkg::frame_t   push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    empty,
    output lsae_pkg::frame_t        head
);

    lsae_pkg::frame_t                 mem_reg [lsae_pkg::QUEUE_DEPTH];
    logic [lsae_pkg::QUEUE_AW-1:0]    wr_reg;
    logic [lsae_pkg::QUEUE_AW-1:0]    rd_reg;
    logic [lsae_pkg::QUEUE_AW:0]      cnt_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign full  = (cnt_reg == (lsae_pkg::QUEUE_AW + 1)'(lsae_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

endmodule

`default_nettype wire

// File: sv/lsae_back.sv
`default_nettype none
// Back end: walks the LEDs of the frame at the queue head, one per cycle while
// out is not stalled, and scales colors in a short pipeline. Depends on lsae_pkg.

module lsae_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lsae_pkg::cfg_t             cfg,
    input  wire logic                       q_empty,
    input  wire lsae_pkg::frame_t           fr,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [lsae_pkg::IDX_W-1:0]      led_index,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            last
);

    logic                               adv;
    logic                               gen;
    logic                               p_last;
    logic [lsae_pkg::CNT_W-1:0]         p_reg;
    logic [8:0]                         wq_reg;
    logic [lsae_pkg::CNT_W-1:0]         wr_reg;
    logic [1:0]                         m3_reg;
    logic [1:0]                         m3_cur;
    logic [lsae_pkg::CNT_W:0]           wr_sum;
    logic                               wr_wrap;
    logic [lsae_pkg::CNT_W:0]           wr_sub;
    logic [lsae_pkg::CNT_W-1:0]         wr_new;
    logic [8:0]                         wq_new;
    logic [7:0]                         w;
    logic [7:0]                         w2;
    logic [9:0]                         w3;
    logic [lsae_pkg::CNT_W-1:0]         head_gap;
    logic                               first;
    logic [7:0]                         pr;
    logic [7:0]                         pg;
    logic [7:0]                         pb;
    logic [8:0]                         plv;

    // Stage registers.
    logic                               v1_reg, v2_reg, v3_reg, vo_reg;
    logic [lsae_pkg::IDX_W-1:0]         i1_reg, i2_reg, i3_reg, io_reg;
    logic                               l1_reg, l2_reg, l3_reg, lo_reg;
    logic [7:0]                         r1_reg, g1_reg, b1_reg;
    logic [8:0]                         lv1_reg;
    logic [16:0]                        r2_reg, g2_reg, b2_reg;
    logic [24:0]                        r3_reg, g3_reg, b3_reg;
    logic [7:0]                         ro_reg, go_reg, bo_reg;

    // Divide by 25600 with saturation: drop 8 bits, then divide by 100
    // through a reciprocal multiply that is exact below 43690, which covers
    // every value that does not saturate.
    function automatic logic [7:0] sat_scale(input logic [24:0] m);
        logic [16:0] y;
        logic [29:0] prod;
        logic [10:0] q;
        begin
            y    = m[24:8];
            prod = 30'(y) * 30'd5243;
            q    = prod[29:19];
            return (q > 11'd255) ? 8'd255 : q[7:0];
        end
    endfunction

    assign adv = !vo_reg || out_ready;
    assign gen = adv && !q_empty;
    assign p_last = (p_reg == fr.n - 7'd1);
    assign pop = gen && p_last;

    // Running counters for the per-LED quotient and the modulo-3 position.
    always_comb
    begin
        m3_cur  = (p_reg == '0) ? fr.aux[1:0] : m3_reg;
        wr_sum  = {1'b0, wr_reg} + {1'b0, fr.aux};
        wr_wrap = wr_sum >= {1'b0, fr.n};
        wr_sub  = wr_sum - {1'b0, fr.n};
        wr_new  = wr_wrap ? wr_sub[lsae_pkg::CNT_W-1:0] : wr_sum[lsae_pkg::CNT_W-1:0];
        wq_new  = wq_reg + fr.qstep + {8'd0, wr_wrap};
    end

    // Color and level of the current LED.
    always_comb
    begin
        pr       = fr.base_r;
        pg       = fr.base_g;
        pb       = fr.base_b;
        plv      = lsae_pkg::LEVEL_FULL;
        w        = wq_reg[7:0] + fr.wofs;
        w2       = w;
        w3       = '0;
        head_gap = (fr.aux > p_reg) ? (fr.aux - p_reg) : (p_reg - fr.aux);
        first    = p_reg < (fr.n >> 1);
        unique case (fr.kind)
            lsae_pkg::KIND_BREATH: plv = fr.level;
            lsae_pkg::KIND_CHASE:
            begin
                if (head_gap == '0)
                begin
                    plv = lsae_pkg::LEVEL_FULL;
                end
                else if (head_gap == 7'd1)
                begin
                    plv = lsae_pkg::LEVEL_NEAR;
                end
                else
                begin
                    plv = lsae_pkg::LEVEL_DIM;
                end
            end
            lsae_pkg::KIND_FILL:
            begin
                plv = (p_reg < fr.aux) ? lsae_pkg::LEVEL_FULL : 9'd0;
            end
            lsae_pkg::KIND_WHEEL:
            begin
                if (w < 8'd85)
                begin
                    w3 = {2'b00, w} + {1'b0, w, 1'b0};
                    pr = w3[7:0];
                    pg = 8'd255 - w3[7:0];
                    pb = 8'd0;
                end
                else if (w < 8'd170)
                begin
                    w2 = w - 8'd85;
                    w3 = {2'b00, w2} + {1'b0, w2, 1'b0};
                    pr = 8'd0;
                    pg = w3[7:0];
                    pb = 8'd255 - w3[7:0];
                end
                else
                begin
                    w2 = w - 8'd170;
                    w3 = {2'b00, w2} + {1'b0, w2, 1'b0};
                    pr = 8'd255 - w3[7:0];
                    pg = 8'd0;
                    pb = w3[7:0];
                end
            end
            lsae_pkg::KIND_THEATRE:
            begin
                pr = (m3_cur == 2'd0) ? lsae_pkg::PRESET_ON : 8'd0;
                pg = pr;
                pb = pr;
            end
            default:
            begin
                pr = ((fr.swap_a && first) || (!fr.swap_a && !first)) ? lsae_pkg::PRESET_ON
                                                                      : 8'd0;
                pg = 8'd0;
                pb = (pr == 8'd0) ? lsae_pkg::PRESET_ON : 8'd0;
            end
        endcase
    end

    // LED walk counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg  <= '0;
            wq_reg <= '0;
            wr_reg <= '0;
            m3_reg <= '0;
        end
        else if (gen)
        begin
            if (p_last)
            begin
                p_reg  <= '0;
                wq_reg <= '0;
                wr_reg <= '0;
            end
            else
            begin
                p_reg  <= p_reg + 7'd1;
                wq_reg <= wq_new;
                wr_reg <= wr_new;
                m3_reg <= (m3_cur == 2'd2) ? 2'd0 : m3_cur + 2'd1;
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= gen;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // Pipeline payload: color, base times level, times percent, final scale.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i1_reg  <= p_reg[lsae_pkg::IDX_W-1:0];
            l1_reg  <= p_last;
            r1_reg  <= pr;
            g1_reg  <= pg;
            b1_reg  <= pb;
            lv1_reg <= plv;

            i2_reg  <= i1_reg;
            l2_reg  <= l1_reg;
            r2_reg  <= 17'(r1_reg) * 17'(lv1_reg);
            g2_reg  <= 17'(g1_reg) * 17'(lv1_reg);
            b2_reg  <= 17'(b1_reg) * 17'(lv1_reg);

            i3_reg  <= i2_reg;
            l3_reg  <= l2_reg;
            r3_reg  <= 25'(r2_reg) * 25'(cfg.pct);
            g3_reg  <= 25'(g2_reg) * 25'(cfg.pct);
            b3_reg  <= 25'(b2_reg) * 25'(cfg.pct);

            io_reg  <= i3_reg;
            lo_reg  <= l3_reg;
            ro_reg  <= sat_scale(r3_reg);
            go_reg  <= sat_scale(g3_reg);
            bo_reg  <= sat_scale(b3_reg);
        end
    end

    assign out_valid = vo_reg;
    assign led_index = io_reg;
    assign red       = ro_reg;
    assign green     = go_reg;
    assign blue      = bo_reg;
    assign last      = lo_reg;

endmodule

`default_nettype wire

// File: sv/led_strip_animation_engine_top.sv
`default_nettype none
// Top level of the LED strip animation engine: configuration registers,
// front end, frame queue and back end. Depends on lsae_pkg and all lsae_ modules.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   now_ms
//   out       output     out_valid / out_ready led_index, red, green, blue, last
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A time item that starts no frame is taken as soon as the front end is idle. A
// frame item holds the front end through the 32-step divider and until its
// frame is pushed into the queue; the back end emits the frame's LEDs one per
// cycle while out_ready is high, each through the back pipeline registers. The
// front end works on the next frame while the back end still emits. Reset
// clears all control state; no clearing pass is needed. A stall on out holds
// the back pipeline, and the front end too once the queue is full.

module led_strip_animation_engine_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [31:0]                now_ms,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [lsae_pkg::IDX_W-1:0]      led_index,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            last,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [15:0]                cfg_data
);

    logic [1:0]                 mode_reg;
    logic [7:0]                 anim_reg;
    logic [7:0]                 color_reg;
    logic [lsae_pkg::CNT_W-1:0] count_reg;
    logic [7:0]                 bright_reg;
    logic [15:0]                interval_reg;
    logic                       cfg_write;
    logic                       cfg_clear;
    lsae_pkg::cfg_t             cfg;
    logic                       push;
    lsae_pkg::frame_t           push_data;
    logic                       q_full;
    logic                       q_empty;
    logic                       pop;
    lsae_pkg::frame_t           head;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_clear = cfg_write && (cfg_index < lsae_pkg::REG_COUNT);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= lsae_pkg::MODE_IDLE;
            anim_reg     <= 8'd0;
            color_reg    <= 8'd0;
            count_reg    <= 7'd1;
            bright_reg   <= 8'd100;
            interval_reg <= 16'd50;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lsae_pkg::REG_MODE:      mode_reg     <= cfg_data[1:0];
                lsae_pkg::REG_ANIM_ID:   anim_reg     <= cfg_data[7:0];
                lsae_pkg::REG_COLOR_ID:  color_reg    <= cfg_data[7:0];
                lsae_pkg::REG_LED_COUNT: count_reg    <= cfg_data[6:0];
                lsae_pkg::REG_BRIGHT:    bright_reg   <= cfg_data[7:0];
                lsae_pkg::REG_INTERVAL:  interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated view of the configuration.
    always_comb
    begin
        cfg.mode     = mode_reg;
        cfg.anim_id  = anim_reg;
        cfg.color_id = color_reg;
        cfg.n        = (count_reg > lsae_pkg::CNT_W'(lsae_pkg::MAX_LEDS))
                       ? lsae_pkg::CNT_W'(lsae_pkg::MAX_LEDS) : count_reg;
        cfg.pct      = ({1'b0, bright_reg} > lsae_pkg::MAX_PCT)
                       ? lsae_pkg::MAX_PCT[7:0] : bright_reg;
        cfg.interval = interval_reg;
    end

    lsae_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_clear  (cfg_clear),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .now_ms     (now_ms),
        .push       (push),
        .push_data  (push_data),
        .queue_full (q_full)
    );

    lsae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    lsae_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .fr        (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .led_index (led_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last      (last)
    );

endmodule

`default_nettype wire

// File: tb/tb_led_strip_animation_engine_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_strip_animation_engine_top: time items in,
// per-LED color items out, checked against an in-bench frame predictor.
// Depends on lsae_pkg and the engine RTL.

module tb_led_strip_animation_engine_top;

    localparam int SETTLE_CYCLES = 60;

    // One expected LED color item.
    typedef struct packed {
        logic [lsae_pkg::IDX_W-1:0] idx;
        logic [7:0]                 r;
        logic [7:0]                 g;
        logic [7:0]                 b;
        logic                       lst;
    } pixel_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [31:0]                  now_ms    = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [lsae_pkg::IDX_W-1:0]   led_index;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
    logic                         last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [2:0]                   cfg_index = '0;
    logic [15:0]                  cfg_data  = '0;

    // Mirror of the configuration registers and the frame state.
    int unsigned cfg_mode;
    int unsigned cfg_anim;
    int unsigned cfg_color;
    int unsigned cfg_count;
    int unsigned cfg_pct;
    int unsigned cfg_interval;
    int unsigned frame_count;
    int unsigned last_frame_time;
    bit          frame_seen;

    pixel_t      pixel_q[$];
    pixel_t      got_px;
    int          errors = 0;
    int          in_gap_pct = 18;
    int          out_stall_pct = 18;

    // Breathing levels in Q8, peak at step six.
    int unsigned breath_tab [24] = '{147, 175, 202, 224, 241, 252, 256, 252, 241, 224, 202, 175,
                                     147, 119, 93, 70, 53, 42, 38, 42, 53, 70, 93, 119};

    // Preset colors as {r, g, b}.
    logic [23:0] preset_tab [8] = '{{8'd125, 8'd125, 8'd125}, {8'd125, 8'd0, 8'd0},
                                    {8'd0, 8'd125, 8'd0}, {8'd0, 8'd0, 8'd125},
                                    {8'd125, 8'd125, 8'd0}, {8'd0, 8'd125, 8'd125},
                                    {8'd125, 8'd0, 8'd125}, {8'd125, 8'd60, 8'd0}};

    led_strip_animation_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .led_index (led_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("led_strip_animation_engine_top test failed");
        $finish;
    end

    // Channel value scaled by brightness and a Q8 level, saturated at 255.
    function automatic logic [7:0] scale_channel(input int unsigned base,
                                                 input int unsigned level);
        int unsigned pct;
        int unsigned v;
        pct = (cfg_pct > 200) ? 200 : cfg_pct;
        v = (base * pct * level) / 25600;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic void push_pixel(input int unsigned p, input int unsigned n,
                                       input int unsigned r, input int unsigned g,
                                       input int unsigned b, input int unsigned level);
        pixel_t px;
        px.idx = p[lsae_pkg::IDX_W-1:0];
        px.r   = scale_channel(r, level);
        px.g   = scale_channel(g, level);
        px.b   = scale_channel(b, level);
        px.lst = (p + 1 == n);
        pixel_q.push_back(px);
    endfunction

    // Decides whether a time item starts a frame and queues its LED colors.
    function automatic void predict_frame(input logic [31:0] t);
        int unsigned n;
        int unsigned p;
        int unsigned ph;
        int unsigned lv;
        int unsigned head;
        int unsigned d;
        int unsigned w;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        logic [23:0] c;
        bit          red_on;
        n = (cfg_count > lsae_pkg::MAX_LEDS) ? lsae_pkg::MAX_LEDS : cfg_count;
        if (cfg_mode != lsae_pkg::MODE_SINGLE && cfg_mode != lsae_pkg::MODE_MULTI)
            return;
        if (n == 0)
            return;
        if (frame_seen && (t - last_frame_time) < cfg_interval)
            return;
        last_frame_time = t;
        frame_seen = 1'b1;
        frame_count = frame_count + 1;
        ph = frame_count;
        c = preset_tab[(cfg_color < 8) ? cfg_color : 0];
        for (p = 0; p < n; p++)
        begin
            if (cfg_mode == lsae_pkg::MODE_SINGLE)
            begin
                if (cfg_anim == 0)
                    lv = breath_tab[ph % 24];
                else if (cfg_anim == 1)
                begin
                    head = ph % n;
                    d = (head > p) ? head - p : p - head;
                    lv = (d == 0) ? 256 : ((d == 1) ? 102 : 20);
                end
                else
                    lv = (p < ph % (n + 1)) ? 256 : 0;
                push_pixel(p, n, c[23:16], c[15:8], c[7:0], lv);
            end
            else
            begin
                r = 0;
                g = 0;
                b = 0;
                if (cfg_anim == 0)
                begin
                    w = ((p * 256) / n + ph * 5) & 255;
                    if (w < 85)
                    begin
                        r = w * 3;
                        g = 255 - w * 3;
                    end
                    else if (w < 170)
                    begin
                        w = w - 85;
                        g = w * 3;
                        b = 255 - w * 3;
                    end
                    else
                    begin
                        w = w - 170;
                        b = w * 3;
                        r = 255 - w * 3;
                    end
                end
                else if (cfg_anim == 1)
                begin
                    if (((p + ph) % 3) == 0)
                    begin
                        r = 125;
                        g = 125;
                        b = 125;
                    end
                end
                else
                begin
                    // Halves trade red and blue every four frames.
                    red_on = (((ph / 4) % 2) == 0) ? (p < n / 2) : !(p < n / 2);
                    if (red_on)
                        r = 125;
                    else
                        b = 125;
                end
                push_pixel(p, n, r, g, b, 256);
            end
        end
    endfunction

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_v, act_v);
            errors++;
        end
    endtask

    // Output side: compares each accepted item and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual led_index %0d",
                         $time, led_index);
                errors++;
            end
            else
            begin
                got_px = pixel_q.pop_front();
                report_field("led_index", got_px.idx, led_index);
                report_field("red", got_px.r, red);
                report_field("green", got_px.g, green);
                report_field("blue", got_px.b, blue);
                report_field("last", got_px.lst, last);
            end
        end
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Sends one time item; valid stays high if the next item follows at once.
    task automatic send_time(input logic [31:0] t);
        while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_frame(t);
    endtask

    // Holds off the sender until every expected item has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        bit listed;
        listed = 1'b1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lsae_pkg::REG_MODE:      cfg_mode = val & 32'h3;
            lsae_pkg::REG_ANIM_ID:   cfg_anim = val & 32'hFF;
            lsae_pkg::REG_COLOR_ID:  cfg_color = val & 32'hFF;
            lsae_pkg::REG_LED_COUNT: cfg_count = val & 32'h7F;
            lsae_pkg::REG_BRIGHT:    cfg_pct = val & 32'hFF;
            lsae_pkg::REG_INTERVAL:  cfg_interval = val & 32'hFFFF;
            default:                 listed = 1'b0;
        endcase
        if (listed)
        begin
            frame_count = 0;
            last_frame_time = 0;
            frame_seen = 1'b0;
        end
    endtask

    // Writes all six registers once the engine is quiet.
    task automatic configure(input int unsigned mode, input int unsigned anim,
                             input int unsigned color, input int unsigned count,
                             input int unsigned pct, input int unsigned interval);
        drain();
        write_reg(lsae_pkg::REG_MODE, mode);
        write_reg(lsae_pkg::REG_ANIM_ID, anim);
        write_reg(lsae_pkg::REG_COLOR_ID, color);
        write_reg(lsae_pkg::REG_LED_COUNT, count);
        write_reg(lsae_pkg::REG_BRIGHT, pct);
        write_reg(lsae_pkg::REG_INTERVAL, interval);
        cfg_valid <= 1'b0;
    endtask

    // Reset state is idle; mode three and a zero LED count emit nothing.
    task automatic test_quiet_cases();
        send_time(32'h0000_0000);
        send_time(32'hFFFF_FFFF);
        configure(3, 0, 0, 8, 100, 0);
        send_time(32'h1234_5678);
        configure(lsae_pkg::MODE_SINGLE, 0, 0, 0, 100, 0);
        send_time(32'h0000_0100);
    endtask

    // Breathing, chase and fill bar with preset, white and out-of-range colors.
    task automatic test_single_color();
        configure(lsae_pkg::MODE_SINGLE, 0, 7, 3, 100, 0);
        send_time(32'd10);
        send_time(32'd10);
        configure(lsae_pkg::MODE_SINGLE, 1, 255, 64, 200, 0);
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        configure(lsae_pkg::MODE_SINGLE, 255, 1, 100, 255, 0);
        send_time(32'd7);
        send_time(32'd8);
    endtask

    // Color wheel on the full strip, theatre chase dark, red/blue swap.
    task automatic test_multi_color();
        configure(lsae_pkg::MODE_MULTI, 0, 0, 64, 100, 0);
        send_time(32'd1);
        send_time(32'd2);
        configure(lsae_pkg::MODE_MULTI, 1, 3, 7, 0, 0);
        send_time(32'd3);
        send_time(32'd4);
        configure(lsae_pkg::MODE_MULTI, 2, 5, 9, 150, 0);
        send_time(32'd5);
        send_time(32'd6);
    endtask

    // Largest interval across the time wrap, then writes beyond the register list.
    task automatic test_interval_wrap();
        logic [31:0] t0;
        t0 = 32'hFFFF_FFF0;
        configure(lsae_pkg::MODE_SINGLE, 1, 2, 2, 100, 65535);
        send_time(t0);
        send_time(t0 + 32'd65534);
        send_time(t0 + 32'd65535);
        // Unlisted indexes must leave the frame timing alone.
        drain();
        write_reg(lsae_pkg::REG_COUNT, $urandom);
        write_reg(lsae_pkg::REG_COUNT + 3'd1, $urandom);
        cfg_valid <= 1'b0;
        send_time(t0 + 32'd65635);
        configure(lsae_pkg::MODE_SINGLE, 1, 2, 2, 100, 1);
        send_time(32'd5);
        send_time(32'd5);
        send_time(32'd6);
    endtask

    // Random settings followed by mostly well-timed frame sequences.
    task automatic run_random_phase(input int items);
        int unsigned mode;
        int unsigned anim;
        int unsigned color;
        int unsigned count;
        int unsigned pct;
        int unsigned interval;
        int unsigned sel;
        logic [31:0] t;
        sel = $urandom_range(99);
        mode = (sel < 45) ? lsae_pkg::MODE_SINGLE : (sel < 90) ? lsae_pkg::MODE_MULTI :
               (sel < 95) ? lsae_pkg::MODE_IDLE : 3;
        sel = $urandom_range(3);
        anim = (sel < 3) ? sel : $urandom_range(2, 255);
        color = ($urandom_range(3) != 0) ? $urandom_range(0, 12) : $urandom_range(13, 255);
        sel = $urandom_range(99);
        if (sel < 70)
            count = $urandom_range(1, 12);
        else if (sel < 88)
            count = $urandom_range(13, 63);
        else if (sel < 94)
            count = lsae_pkg::MAX_LEDS;
        else if (sel < 98)
            count = $urandom_range(65, 127);
        else
            count = 0;
        case ($urandom_range(5))
            0:       pct = 0;
            1:       pct = 100;
            2:       pct = 200;
            3:       pct = 255;
            4:       pct = $urandom_range(0, 255);
            default: pct = $urandom_range(1, 200);
        endcase
        sel = $urandom_range(99);
        if (sel < 60)
            interval = $urandom_range(1, 20);
        else if (sel < 75)
            interval = 0;
        else if (sel < 85)
            interval = 65535;
        else
            interval = $urandom_range(21, 65535);
        configure(mode, anim, color, count, pct, interval);
        t = $urandom;
        for (int i = 0; i < items; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
                t = t + interval + $urandom_range(0, 5);
            else if (sel < 88)
                t = t + $urandom_range(0, interval);
            else
                t = $urandom;
            send_time(t);
        end
    endtask

    task automatic test_random();
        // First phase runs with both sides always ready.
        in_gap_pct = 0;
        out_stall_pct = 0;
        run_random_phase(20);
        in_gap_pct = 18;
        out_stall_pct = 18;
        for (int ph = 0; ph < 6; ph++)
            run_random_phase(20);
    endtask

    initial
    begin
        cfg_mode = lsae_pkg::MODE_IDLE;
        cfg_anim = 0;
        cfg_color = 0;
        cfg_count = 1;
        cfg_pct = 100;
        cfg_interval = 50;
        frame_count = 0;
        last_frame_time = 0;
        frame_seen = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_quiet_cases();
        test_single_color();
        test_multi_color();
        test_interval_wrap();
        test_random();
        drain();
        if (errors == 0)
            $display("led_strip_animation_engine_top test passed");
        else
            $display("led_strip_animation_engine_top test failed");
        $finish;
    end

endmodule
